[rtl/assert_macros.svh]
// Assertion macros for the queue top level; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/fqd_pkg.sv]
// Types, codes and constants of the handle queue with delete.
package fqd_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int VALUE_W          = 32;
   localparam int LEN_W            = 7;

   // Operation codes; code three is unused
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_DELETE  = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   // Control broadcast to every cell of the chain
   typedef struct packed {
      logic cmp_en;    // register the match bit against the request value
      logic enq_en;    // write the tail cell
      logic del_mode;  // cells at and after the first match shift towards the head
   } cell_ctrl_type;

endpackage

[rtl/fifo_queue_with_delete_core.sv]
// Top level: handle queue with enqueue, dequeue and delete-by-value.
// rsp_strobe rises after the start transfer once the sequencer has passed through ST_APPLY
// and the result registers have loaded. busy is high for one cycle, in ST_APPLY, so no new
// request is taken before the last one is applied; the cell chain compares, then shifts.
// Results cannot be stalled: each shows on rsp_* for a single cycle with rsp_strobe.
// Reset (synchronous, active high) empties the queue; slot contents are not cleared.
module fifo_queue_with_delete_core
   import fqd_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [VALUE_W-1:0] req_entry_value,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [VALUE_W-1:0] rsp_out_value,
   output logic [LEN_W-1:0]   rsp_fill_level
);

`include "assert_macros.svh"

   localparam int CW = $clog2(CAPACITY+1);

   typedef enum logic {ST_IDLE, ST_APPLY} state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   cell_ctrl_type      ctrl;
   logic               accept;
   logic               apply;
   logic               dq_mode;
   logic [CAPACITY:0]  sel_chain;
   logic [VALUE_W-1:0] data_vec [CAPACITY];
   logic [CW+LEN_W-1:0] len_ext;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign apply  = (state_ff == ST_APPLY);

   // Broadcast control to the cells
   assign dq_mode       = apply && (op_ff == OP_DEQUEUE) && (count_ff != '0);
   assign ctrl.cmp_en   = accept;
   assign ctrl.enq_en   = apply && (op_ff == OP_ENQUEUE) && (count_ff != CW'(CAPACITY));
   assign ctrl.del_mode = apply && (op_ff == OP_DELETE) && (val_ff != '0);
   assign sel_chain[0]  = dq_mode;

   // Cell chain, slot 0 is the head
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] nxt;
      if (i == CAPACITY - 1) begin : g_last
         assign nxt = data_vec[i];
      end else begin : g_mid
         assign nxt = data_vec[i+1];
      end
      fqd_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .cmp_value (req_entry_value),
         .wr_value  (val_ff),
         .next_data (nxt),
         .sel_in    (sel_chain[i]),
         .sel_out   (sel_chain[i+1]),
         .data_out  (data_vec[i])
      );
   end

   // Sequencer and result registers
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               val_in   = req_entry_value;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_value_in  = '0;
            rsp_status_in = STAT_OK;
            case (op_ff)
               OP_ENQUEUE: begin
                  if (count_ff == CW'(CAPACITY)) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_DEQUEUE: begin
                  if (count_ff == '0) begin
                     rsp_status_in = STAT_EMPTY;
                  end else begin
                     rsp_value_in = data_vec[0];
                     count_in     = count_ff - CW'(1);
                  end
               end
               OP_DELETE: begin
                  if (sel_chain[CAPACITY]) begin
                     count_in = count_ff - CW'(1);
                  end else begin
                     rsp_status_in = STAT_NOTFOUND;
                  end
               end
               default: begin
                  rsp_status_in = STAT_NOTFOUND;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Length reported modulo 128
   assign len_ext        = {{LEN_W{1'b0}}, count_ff};
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_fill_level = len_ext[LEN_W-1:0];

   // Checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_strobe, "accept did not start work")
   `ASSERT_NEXT(a_apply_strobe, clock, reset, apply, rsp_strobe && !busy, "missing result strobe")
   `ASSERT_IMPLY(a_value_zero, clock, reset, rsp_strobe && (rsp_status != STAT_OK), rsp_out_value == '0, "value on failure")

endmodule

[rtl/fqd_cell.sv]
// One queue slot: holds a handle, compares it and shifts towards the head.
module fqd_cell
   import fqd_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int INDEX    = 0
) (
   input  logic                           clock,
   input  cell_ctrl_type                  ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0]  count,
   input  logic [VALUE_W-1:0]             cmp_value,
   input  logic [VALUE_W-1:0]             wr_value,
   input  logic [VALUE_W-1:0]             next_data,
   input  logic                           sel_in,
   output logic                           sel_out,
   output logic [VALUE_W-1:0]             data_out
);

   localparam int CW = $clog2(CAPACITY+1);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;
   logic               match_ff;
   logic               match_in;
   logic               occupied;

   assign occupied = CW'(INDEX) < count;

   // Shift select runs down the chain: set from the first match onwards on a delete, in every cell on a dequeue
   assign sel_out  = sel_in | (ctrl.del_mode & match_ff);
   assign data_out = data_ff;

   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = occupied && (data_ff == cmp_value);
      end
      data_in = data_ff;
      if (ctrl.enq_en && (count == CW'(INDEX))) begin
         data_in = wr_value;
      end else if (sel_out) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

endmodule

[tb/sv/fqd_queue_checker.sv]
// Checker for the handle queue: predicts each result and compares it with the block's output.
`timescale 1ns / 100ps
module fqd_queue_checker
   import fqd_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [VALUE_W-1:0] req_entry_value,
   input  logic               rsp_strobe,
   input  logic [1:0]         rsp_status,
   input  logic [VALUE_W-1:0] rsp_out_value,
   input  logic [LEN_W-1:0]   rsp_fill_level,
   output int                 mismatch_count,
   output int                 outstanding_results
);

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] out_value;
      logic [LEN_W-1:0]   fill_level;
   } queue_result_type;

   // Shadow of the queue contents, head at index 0
   logic [VALUE_W-1:0] held_handles[$];
   // Results predicted but not yet seen on rsp_*
   queue_result_type   awaited_results[$];
   int                 fail_total   = 0;
   int                 report_count = 0;

   // Apply one operation to the shadow queue and return the result it should give
   function automatic queue_result_type apply_queue_op(input logic [1:0]         op,
                                                       input logic [VALUE_W-1:0] handle);
      queue_result_type r;
      int               match_pos;
      r.status    = STAT_OK;
      r.out_value = '0;
      match_pos   = -1;
      case (op)
         OP_ENQUEUE: begin
            if (held_handles.size() >= CAPACITY) r.status = STAT_FULL;
            else held_handles.push_back(handle);
         end
         OP_DEQUEUE: begin
            if (held_handles.size() == 0) r.status = STAT_EMPTY;
            else r.out_value = held_handles.pop_front();
         end
         OP_DELETE: begin
            // null handle is never matched; otherwise first hit from the head
            if (handle != '0) begin
               for (int i = 0; i < held_handles.size(); i++) begin
                  if (match_pos < 0 && held_handles[i] == handle) match_pos = i;
               end
            end
            if (match_pos < 0) r.status = STAT_NOTFOUND;
            else held_handles.delete(match_pos);
         end
         default: r.status = STAT_NOTFOUND;
      endcase
      r.fill_level = LEN_W'(held_handles.size());
      return r;
   endfunction

   // Compare result transfers first, then record the prediction for a new request
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         held_handles.delete();
         awaited_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               fail_total++;
               if (report_count < 10) begin
                  report_count++;
                  $display("%0t: unexpected result: status %0d value %h length %0d",
                           $realtime, rsp_status, rsp_out_value, rsp_fill_level);
               end
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status || rsp_out_value !== want.out_value ||
                   rsp_fill_level !== want.fill_level) begin
                  fail_total++;
                  if (report_count < 10) begin
                     report_count++;
                     $display("%0t: mismatch: status exp %0d got %0d, value exp %h got %h, %s",
                              $realtime, want.status, rsp_status, want.out_value,
                              rsp_out_value,
                              $sformatf("length exp %0d got %0d",
                                        want.fill_level, rsp_fill_level));
                  end
               end
            end
         end
         if (start && !busy) awaited_results.push_back(apply_queue_op(req_opcode,
                                                                      req_entry_value));
      end
      mismatch_count      <= fail_total;
      outstanding_results <= awaited_results.size();
   end

endmodule

[tb/sv/tb_fifo_queue_with_delete_core.sv]
// Testbench top: stimulus, clock, reset, watchdog and verdict for the handle queue.
`timescale 1ns / 100ps
module tb_fifo_queue_with_delete_core
   import fqd_pkg::*;
();

   localparam int         ITEM_TARGET = 1800;
   localparam int         QUIET_LIMIT = 400;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode      = OP_ENQUEUE;
   logic [VALUE_W-1:0] req_entry_value = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic [VALUE_W-1:0] rsp_out_value;
   logic [LEN_W-1:0]   rsp_fill_level;
   int                 mismatch_count;
   int                 outstanding_results;
   int                 burst_left   = 3;
   int                 quiet_cycles = 0;

   always #5 clock = ~clock;

   fifo_queue_with_delete_core uut (.*);

   fqd_queue_checker queue_check (.*);

   // Watchdog: cycles without any transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // One request transfer; the sender drops start for a random gap between bursts
   task automatic issue_op(input logic [1:0] op, input logic [VALUE_W-1:0] handle);
      start           <= 1'b1;
      req_opcode      <= op;
      req_entry_value <= handle;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 12);
      end
   endtask

   // Handles: mostly a small pool so deletes hit, plus null, all-ones, one-hot and random
   function automatic logic [VALUE_W-1:0] pick_handle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return VALUE_W'($urandom_range(1, 8));
      else if (roll < 63) return '0;
      else if (roll < 70) return '1;
      else if (roll < 78) return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      else return $urandom();
   endfunction

   function automatic logic [1:0] pick_op(input op_mix_type mix);
      int roll;
      int enq_pct;
      int deq_pct;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            enq_pct = 80;
            deq_pct = 7;
         end
         MIX_DRAIN: begin
            enq_pct = 12;
            deq_pct = 50;
         end
         default: begin
            enq_pct = 45;
            deq_pct = 27;
         end
      endcase
      if (roll < 3) return OP_UNUSED;
      else if (roll < 3 + enq_pct) return OP_ENQUEUE;
      else if (roll < 3 + enq_pct + deq_pct) return OP_DEQUEUE;
      else return OP_DELETE;
   endfunction

   initial begin
      int         issued;
      int         phase;
      int         phase_len;
      op_mix_type mix;
      issued = 0;
      phase  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queue corner cases
      issue_op(OP_DEQUEUE, 32'hFFFF_FFFF);
      issue_op(OP_DELETE, 32'h0000_0005);
      issue_op(OP_DELETE, 32'h0000_0000);
      issue_op(OP_UNUSED, 32'hFFFF_FFFF);
      // null and extreme handles, a duplicate
      issue_op(OP_ENQUEUE, 32'h0000_0000);
      issue_op(OP_ENQUEUE, 32'hFFFF_FFFF);
      issue_op(OP_ENQUEUE, 32'h8000_0001);
      issue_op(OP_ENQUEUE, 32'h1234_5678);
      issue_op(OP_ENQUEUE, 32'hFFFF_FFFF);
      issue_op(OP_DELETE, 32'h0000_0000);
      // delete from the middle (first of two copies), from the middle again, and a miss
      issue_op(OP_DELETE, 32'hFFFF_FFFF);
      issue_op(OP_DELETE, 32'h1234_5678);
      issue_op(OP_DELETE, 32'h0000_DEAD);
      issue_op(OP_UNUSED, 32'h8000_0001);
      // dequeue of a stored null handle, then of the next handle
      issue_op(OP_DEQUEUE, 32'h0000_0000);
      issue_op(OP_DEQUEUE, 32'h5555_5555);
      // delete at the head, leaving the queue empty
      issue_op(OP_DELETE, 32'hFFFF_FFFF);
      issue_op(OP_DEQUEUE, 32'hAAAA_AAAA);
      issue_op(OP_ENQUEUE, 32'h0000_0007);
      issue_op(OP_ENQUEUE, 32'h0000_0007);
      issue_op(OP_DELETE, 32'h0000_0007);
      issue_op(OP_DEQUEUE, 32'h0000_0000);

      // Random phases: a fill-heavy mix first, then a drain-heavy mix, then mixed traffic
      while (issued < ITEM_TARGET) begin
         if (phase == 0) mix = MIX_FILL;
         else if (phase == 1) mix = MIX_DRAIN;
         else mix = op_mix_type'($urandom_range(0, 2));
         phase_len = (phase < 2) ? 200 : $urandom_range(40, 200);
         for (int k = 0; k < phase_len && issued < ITEM_TARGET; k++) begin
            issue_op(pick_op(mix), pick_handle());
            issued++;
         end
         phase++;
      end
      start <= 1'b0;

      // Drain outstanding results, then allow for the block's latency
      do @(posedge clock); while (outstanding_results != 0);
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && outstanding_results == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/fqd_pkg.sv
rtl/fqd_cell.sv
rtl/fifo_queue_with_delete_core.sv
tb/sv/fqd_queue_checker.sv
tb/sv/tb_fifo_queue_with_delete_core.sv
